// ----- rtl/dpd_pkg.sv -----
package dpd_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int POS_BITS   = 10;
    localparam int TOL_BITS   = 8;
    localparam int QUOT_BITS  = 11;
    localparam int CFG_BITS   = 10;
    localparam int DIGIT_BITS = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_BITS   = 4;

    localparam logic [POS_BITS-1:0] FULL_SCALE = 10'd1000;

    localparam logic [POS_BITS-1:0] THRESHOLD_RESET = 10'd20;
    localparam logic [TOL_BITS-1:0] TOLERANCE_RESET = 8'd40;

    localparam logic [POS_BITS-1:0] DIGIT_TABLE [NUM_DIGITS] = '{
        10'd30, 10'd155, 10'd252, 10'd390, 10'd500,
        10'd620, 10'd750, 10'd860, 10'd970, 10'd1000
    };

    // Output field widths packed into m_tdata
    localparam int OUT_FIELD_BITS = 2 + DIGIT_BITS + POS_BITS + POS_BITS;
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DIGIT  = 2'd1,
        EV_REJECT = 2'd2
    } ev_t;

    typedef enum logic {
        REG_PEAK_THRESHOLD  = 1'b0,
        REG_MATCH_TOLERANCE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_CLASS
    } state_t;

    typedef struct packed {
        logic load;     // capture input transfer
        logic mul;      // form wiper * full scale
        logic prep;     // saturation check, divider setup
        logic step;     // one quotient bit
        logic finish;   // peak update, classification, output load
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_sts_t;

endpackage

// ----- rtl/dpd_ctrl.sv -----
module dpd_ctrl
    import dpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:   cmd.mul    = 1'b1;
            ST_PREP:  cmd.prep   = 1'b1;
            ST_DIV:   cmd.step   = 1'b1;
            ST_CLASS: cmd.finish = out_free;
            default:  cmd        = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/dpd_datapath.sv -----
module dpd_datapath
    import dpd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_sts_t                sts,
    input  logic [SAMPLE_BITS-1:0] wiper_sample,
    input  logic [SAMPLE_BITS-1:0] reference_sample,
    input  logic                   enable,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data,
    output ev_t                    event_res,
    output logic [DIGIT_BITS-1:0]  digit,
    output logic [POS_BITS-1:0]    peak_value,
    output logic [POS_BITS-1:0]    position
);

    localparam int NUM_BITS = SAMPLE_BITS + POS_BITS;

    logic [SAMPLE_BITS-1:0] w_reg, r_reg;
    logic                   en_reg;
    logic [NUM_BITS-1:0]    rem_reg, rem_next;
    logic [NUM_BITS-1:0]    dsr_reg, dsr_next;
    logic [QUOT_BITS-1:0]   quot_reg, quot_next;
    logic                   sat_reg, sat_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;

    logic [POS_BITS-1:0]    thr_reg, thr_next;
    logic [TOL_BITS-1:0]    tol_reg, tol_next;
    logic [POS_BITS-1:0]    peak_reg, peak_next;

    ev_t                    ev_reg, ev_next;
    logic [DIGIT_BITS-1:0]  dg_reg, dg_next;
    logic [POS_BITS-1:0]    pv_reg, pv_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;

    logic [NUM_BITS-1:0]    product;
    logic [NUM_BITS:0]      rem_diff;
    logic [POS_BITS-1:0]    ratio;
    logic [POS_BITS-1:0]    pos;
    logic [POS_BITS-1:0]    peak_upd;
    logic                   at_rest_classify;

    // classification
    logic [NUM_DIGITS-1:0]  hit;
    logic [DIGIT_BITS-1:0]  match_idx;
    logic                   found;
    logic                   reject;
    logic [DIGIT_BITS-1:0]  start_idx;
    logic [POS_BITS:0]      peak_plus_tol;

    assign product  = NUM_BITS'(w_reg) * NUM_BITS'(FULL_SCALE);
    assign rem_diff = {1'b0, rem_reg} - {1'b0, dsr_reg};

    // Divider: restoring, one quotient bit per step, divisor shifts right
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        if (cmd.mul)
        begin
            rem_next = product;
        end
        else if (cmd.prep)
        begin
            // ratio >= 2048 (or zero reference) saturates straight to full scale
            sat_next  = {1'b0, rem_reg} >= {r_reg, {(QUOT_BITS){1'b0}}};
            dsr_next  = {r_reg, {(QUOT_BITS-1){1'b0}}};
            quot_next = '0;
            cnt_next  = CNT_BITS'(QUOT_BITS - 1);
        end
        else if (cmd.step)
        begin
            if (!rem_diff[NUM_BITS])
                rem_next = rem_diff[NUM_BITS-1:0];
            quot_next = {quot_reg[QUOT_BITS-2:0], !rem_diff[NUM_BITS]};
            dsr_next  = dsr_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    assign sts.div_last = (cnt_reg == '0);

    always_comb
    begin
        if (sat_reg || quot_reg > {1'b0, FULL_SCALE})
            ratio = FULL_SCALE;
        else
            ratio = quot_reg[POS_BITS-1:0];
    end

    assign pos      = FULL_SCALE - ratio;
    assign peak_upd = (pos > peak_reg) ? pos : peak_reg;
    assign at_rest_classify = en_reg && (pos == '0) && (peak_upd > thr_reg);

    // Full-scale peak jumps straight to the last entry
    assign start_idx     = (peak_upd == FULL_SCALE) ? DIGIT_BITS'(NUM_DIGITS - 1) : '0;
    assign peak_plus_tol = {1'b0, peak_upd} + {{(POS_BITS-TOL_BITS+1){1'b0}}, tol_reg};

    always_comb
    begin
        for (int n = 0; n < NUM_DIGITS; n++)
        begin
            hit[n] = ({1'b0, peak_upd} <=
                      {1'b0, DIGIT_TABLE[n]} + {{(POS_BITS-TOL_BITS+1){1'b0}}, tol_reg})
                     && (DIGIT_BITS'(n) >= start_idx);
        end
    end

    always_comb
    begin
        match_idx = '0;
        found     = 1'b0;
        for (int n = NUM_DIGITS - 1; n >= 0; n--)
        begin
            if (hit[n])
            begin
                match_idx = DIGIT_BITS'(n);
                found     = 1'b1;
            end
        end
    end

    assign reject = !found || (peak_plus_tol < {1'b0, DIGIT_TABLE[match_idx]});

    always_comb
    begin
        peak_next = peak_reg;
        ev_next   = ev_reg;
        dg_next   = dg_reg;
        pv_next   = pv_reg;
        pos_next  = pos_reg;
        if (cmd.finish)
        begin
            pos_next = pos;
            ev_next  = EV_NONE;
            dg_next  = '0;
            pv_next  = '0;
            if (en_reg)
                peak_next = peak_upd;
            if (at_rest_classify)
            begin
                pv_next   = peak_upd;
                peak_next = '0;
                if (reject)
                    ev_next = EV_REJECT;
                else
                begin
                    ev_next = EV_DIGIT;
                    dg_next = match_idx;
                end
            end
        end
    end

    always_comb
    begin
        thr_next = thr_reg;
        tol_next = tol_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PEAK_THRESHOLD:  thr_next = cfg_data;
                REG_MATCH_TOLERANCE: tol_next = cfg_data[TOL_BITS-1:0];
                default:             thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            tol_reg  <= TOLERANCE_RESET;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            thr_reg  <= thr_next;
            tol_reg  <= tol_next;
            peak_reg <= peak_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg  <= wiper_sample;
            r_reg  <= reference_sample;
            en_reg <= enable;
        end
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
        ev_reg   <= ev_next;
        dg_reg   <= dg_next;
        pv_reg   <= pv_next;
        pos_reg  <= pos_next;
    end

    assign event_res  = ev_reg;
    assign digit      = dg_reg;
    assign peak_value = pv_reg;
    assign position   = pos_reg;

endmodule

// ----- rtl/dial_position_digit_decoder_core.sv -----
// Sequence per input transfer: 1 multiply, 1 setup, 11 divider steps,
//   1 classify, plus any wait on a held output register.
// Processing: one item at a time through the serial restoring divider; the
//   next input is accepted only when the controller is back in idle.
// Reset (rst_n, async, active low): idle, output empty, peak 0,
//   threshold 20, tolerance 40.
module dial_position_digit_decoder_core
    import dpd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // wiper_sample [SAMPLE_BITS-1:0], reference_sample, enable, zero pad
    input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]   s_tdata,
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // event_res [1:0], digit [5:2], peak_value [15:6], position [25:16], zero pad
    output logic [OUT_BITS-1:0]                  m_tdata,
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [CFG_BITS-1:0]                  cfg_data
);

    localparam int IN_BITS = ((2*SAMPLE_BITS+8)/8)*8;

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    ev_t                   event_res;
    logic [DIGIT_BITS-1:0] digit;
    logic [POS_BITS-1:0]   peak_value;
    logic [POS_BITS-1:0]   position;

    // Controller sequences one item at a time: the input side is ready
    // whenever the controller is idle, even with a result still waiting
    // in the output register.
    dpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: product, divider, peak tracking, table match, output register
    dpd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .wiper_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .reference_sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .enable           (s_tdata[2*SAMPLE_BITS]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .event_res        (event_res),
        .digit            (digit),
        .peak_value       (peak_value),
        .position         (position)
    );

    // Pad bits above enable in s_tdata are don't-care
    logic unused_pad;
    assign unused_pad = ^s_tdata[IN_BITS-1:2*SAMPLE_BITS+1];

    assign m_tdata = {{(OUT_BITS-OUT_FIELD_BITS){unused_pad & 1'b0}},
                      position, peak_value, digit, event_res};

endmodule
